/* design/bhdc_pkg.sv */
`default_nettype none

package bhdc_pkg;

  // Configuration register indexes on the write port.
  typedef enum logic [2:0] {
    REG_KNOB_ON_THRESHOLD = 3'd0,
    REG_KNOB_MAX          = 3'd1,
    REG_TARGET_MIN        = 3'd2,
    REG_TARGET_MAX        = 3'd3,
    REG_OVERHEAT_LIMIT    = 3'd4,
    REG_HOLD_TOLERANCE    = 3'd5,
    REG_EMERGENCY_MARGIN  = 3'd6,
    REG_PWM_TOP           = 3'd7
  } cfg_reg_e;

  // Operating mode reported with every result.
  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_ON       = 2'd1,
    MODE_OVERHEAT = 2'd2
  } mode_e;

  // Duty band selected from the temperature error.
  typedef enum logic [2:0] {
    BAND_HOT,
    BAND_UPPER,
    BAND_LOWER,
    BAND_COLD,
    BAND_HOLD
  } band_e;

  // Knob event codes.
  localparam logic [1:0] KNOB_UP   = 2'd1;
  localparam logic [1:0] KNOB_DOWN = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef struct packed {
    logic [7:0]  knob_on_threshold;
    logic [7:0]  knob_max;
    logic [7:0]  target_min;
    logic [7:0]  target_max;
    logic [11:0] overheat_limit;
    logic [7:0]  hold_tolerance;
    logic [9:0]  emergency_margin;
    logic [15:0] pwm_top;
  } cfg_t;

  // Register values after reset.
  localparam cfg_t CFG_RESET = '{
    knob_on_threshold: 8'd27,
    knob_max:          8'd150,
    target_min:        8'd30,
    target_max:        8'd150,
    overheat_limit:    12'd2560,
    hold_tolerance:    8'd32,
    emergency_margin:  10'd240,
    pwm_top:           16'd511
  };

  localparam logic [7:0] KNOB_RESET   = 8'd27;
  localparam logic [7:0] TARGET_RESET = 8'd30;

  // Knob position and target after a step.
  typedef struct packed {
    logic [7:0] knob;
    logic [7:0] target;
  } knob_state_t;

  typedef struct packed {
    logic signed [12:0] bed_temp;
    logic [1:0]         knob_step;
  } in_t;

  typedef struct packed {
    logic [6:0]  duty_percent;
    logic [15:0] compare_value;
    mode_e       system_mode;
    logic        heating_on;
    logic [7:0]  knob_position;
    logic [7:0]  target_temp;
  } out_t;

  // Band edges on the error, in 1/16 degree.
  localparam logic signed [14:0] EDGE_HOT   = 15'sd160;
  localparam logic signed [14:0] EDGE_UPPER = 15'sd80;

  // Interpolation limits and duty levels.
  localparam logic [7:0] UPPER_X_LO = 8'd50;
  localparam logic [8:0] LOWER_X_LO = 9'd20;
  localparam logic [8:0] X_HI       = 9'd100;
  localparam logic [6:0] DUTY_HOT   = 7'd80;
  localparam logic [6:0] DUTY_UPPER = 7'd40;
  localparam logic [6:0] DUTY_LOWER = 7'd20;
  localparam logic [6:0] DUTY_HOLD  = 7'd15;
  localparam logic [6:0] DUTY_MAX   = 7'd100;

  // floor(y * 3 / 5) for y up to 50 is (y * 615) >> 10.
  localparam logic [15:0] RECIP_3_5 = 16'd615;

  // floor(2^30 / 100); the estimate is at most one short of the quotient.
  localparam logic [23:0] DIV100_RECIP = 24'd10737418;
  localparam logic [22:0] DIV100_D     = 23'd100;

endpackage

`default_nettype wire

/* design/bhdc_knob_ctrl.sv */
`default_nettype none

module bhdc_knob_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_en_i,
  input  wire [1:0]            knob_step_i,
  input  bhdc_pkg::cfg_t       cfg_i,
  output bhdc_pkg::knob_state_t state_o
);

  logic [7:0] knob_q, knob_d;
  logic [7:0] target_q, target_d;
  logic [8:0] knob_inc;

  // Saturating knob step and the target that follows it.
  always_comb begin
    knob_inc = {1'b0, knob_q} + 9'd1;
    knob_d   = knob_q;
    unique case (knob_step_i)
      bhdc_pkg::KNOB_UP: begin
        knob_d = (knob_inc > {1'b0, cfg_i.knob_max}) ? cfg_i.knob_max : knob_inc[7:0];
      end
      bhdc_pkg::KNOB_DOWN: begin
        knob_d = (knob_q == 8'd0) ? 8'd0 : knob_q - 8'd1;
      end
      default: begin
        knob_d = knob_q;
      end
    endcase

    target_d = target_q;
    if (knob_d >= cfg_i.knob_on_threshold) begin
      if (knob_d < cfg_i.target_min) begin
        target_d = cfg_i.target_min;
      end else if (knob_d > cfg_i.target_max) begin
        target_d = cfg_i.target_max;
      end else begin
        target_d = knob_d;
      end
    end
  end

  // State moves only when a request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knob_q   <= bhdc_pkg::KNOB_RESET;
      target_q <= bhdc_pkg::TARGET_RESET;
    end else if (step_en_i) begin
      knob_q   <= knob_d;
      target_q <= target_d;
    end
  end

  assign state_o.knob   = knob_d;
  assign state_o.target = target_d;

endmodule

`default_nettype wire

/* design/banded_heater_duty_controller_core.sv */
`default_nettype none

// Banded heater duty controller. One request (a bed temperature and a knob
// event) is taken in every clock cycle while the input is not stalled. The
// request passes six register stages: the input register, the band stage, the
// duty stage, two multiplier stages that scale the duty by pwm_top / 100, and
// the result register after the correction of the quotient, which offers the
// result. A result waiting at the output does not block new requests until
// all six stages hold one. Configuration registers are to be written through
// the plain write port while no request is in flight; the block itself does
// not enforce this.
module banded_heater_duty_controller_core (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  bhdc_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output bhdc_pkg::out_t                      out_data_o,
  input  wire                                 cfg_we_i,
  input  wire [bhdc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire [bhdc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  bhdc_pkg::cfg_t        cfg_q;
  bhdc_pkg::knob_state_t knob_state;

  logic [6:1] valid_q;
  logic [6:1] vin;
  logic [6:1] rdy;
  logic [6:1] load;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bhdc_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (bhdc_pkg::cfg_reg_e'(cfg_idx_i))
        bhdc_pkg::REG_KNOB_ON_THRESHOLD: cfg_q.knob_on_threshold <= cfg_wdata_i[7:0];
        bhdc_pkg::REG_KNOB_MAX:          cfg_q.knob_max          <= cfg_wdata_i[7:0];
        bhdc_pkg::REG_TARGET_MIN:        cfg_q.target_min        <= cfg_wdata_i[7:0];
        bhdc_pkg::REG_TARGET_MAX:        cfg_q.target_max        <= cfg_wdata_i[7:0];
        bhdc_pkg::REG_OVERHEAT_LIMIT:    cfg_q.overheat_limit    <= cfg_wdata_i[11:0];
        bhdc_pkg::REG_HOLD_TOLERANCE:    cfg_q.hold_tolerance    <= cfg_wdata_i[7:0];
        bhdc_pkg::REG_EMERGENCY_MARGIN:  cfg_q.emergency_margin  <= cfg_wdata_i[9:0];
        bhdc_pkg::REG_PWM_TOP:           cfg_q.pwm_top           <= cfg_wdata_i[15:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // Pipeline flow control: a stage moves when it is empty or its successor moves.
  always_comb begin
    rdy[6] = !valid_q[6] || !out_stall_i;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    vin  = {valid_q[5:1], in_valid_i};
    load = rdy & vin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 1; k <= 6; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= vin[k];
        end
      end
    end
  end

  assign in_stall_o = !rdy[1];

  // Knob and target state, updated as each request is taken.
  bhdc_knob_ctrl u_knob (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (load[1]),
    .knob_step_i (in_data_i.knob_step),
    .cfg_i       (cfg_q),
    .state_o     (knob_state)
  );

  // Stage 1: input register.
  logic signed [12:0] s1_temp_q;
  logic [7:0]         s1_knob_q, s1_tgt_q;

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      s1_temp_q <= in_data_i.bed_temp;
      s1_knob_q <= knob_state.knob;
      s1_tgt_q  <= knob_state.target;
    end
  end

  // Stage 2: error, mode, band and interpolation point.
  logic signed [14:0] err, temp_x, ovl_x, tol_x, marg_x;
  logic [10:0]        err_x5;
  logic [7:0]         xu_raw;
  logic [8:0]         xl_raw;
  logic [6:0]         x_d;
  bhdc_pkg::mode_e    mode_d;
  bhdc_pkg::band_e    band_d;
  logic               emerg_d;

  always_comb begin
    temp_x = {{2{s1_temp_q[12]}}, s1_temp_q};
    ovl_x  = {3'b000, cfg_q.overheat_limit};
    tol_x  = {7'b0, cfg_q.hold_tolerance};
    marg_x = {5'b0, cfg_q.emergency_margin};
    err    = {3'b000, s1_tgt_q, 4'b0000} - temp_x;

    if (temp_x >= ovl_x) begin
      mode_d = bhdc_pkg::MODE_OVERHEAT;
    end else if (s1_knob_q < cfg_q.knob_on_threshold) begin
      mode_d = bhdc_pkg::MODE_OFF;
    end else begin
      mode_d = bhdc_pkg::MODE_ON;
    end

    if (err > bhdc_pkg::EDGE_HOT) begin
      band_d = bhdc_pkg::BAND_HOT;
    end else if (err > bhdc_pkg::EDGE_UPPER) begin
      band_d = bhdc_pkg::BAND_UPPER;
    end else if (err > tol_x) begin
      band_d = bhdc_pkg::BAND_LOWER;
    end else if (err < -tol_x) begin
      band_d = bhdc_pkg::BAND_COLD;
    end else begin
      band_d = bhdc_pkg::BAND_HOLD;
    end

    emerg_d = (err < -marg_x);

    // Inside both interpolated bands the error fits in eight bits.
    err_x5 = ({3'b000, err[7:0]} << 2) + {3'b000, err[7:0]};
    xu_raw = err_x5[10:3];
    xl_raw = err_x5[10:2];

    if (band_d == bhdc_pkg::BAND_UPPER) begin
      if (xu_raw < bhdc_pkg::UPPER_X_LO) begin
        x_d = bhdc_pkg::UPPER_X_LO[6:0];
      end else if ({1'b0, xu_raw} > bhdc_pkg::X_HI) begin
        x_d = bhdc_pkg::X_HI[6:0];
      end else begin
        x_d = xu_raw[6:0];
      end
    end else begin
      if (xl_raw < bhdc_pkg::LOWER_X_LO) begin
        x_d = bhdc_pkg::LOWER_X_LO[6:0];
      end else if (xl_raw > bhdc_pkg::X_HI) begin
        x_d = bhdc_pkg::X_HI[6:0];
      end else begin
        x_d = xl_raw[6:0];
      end
    end
  end

  bhdc_pkg::mode_e s2_mode_q;
  bhdc_pkg::band_e s2_band_q;
  logic            s2_emerg_q;
  logic [6:0]      s2_x_q;
  logic [7:0]      s2_knob_q, s2_tgt_q;

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      s2_mode_q  <= mode_d;
      s2_band_q  <= band_d;
      s2_emerg_q <= emerg_d;
      s2_x_q     <= x_d;
      s2_knob_q  <= s1_knob_q;
      s2_tgt_q   <= s1_tgt_q;
    end
  end

  // Stage 3: duty and heating flag.
  logic [6:0]  xu_off, xl_off;
  logic [15:0] upper_prod;
  logic [6:0]  duty_d;
  logic        heat_d;

  always_comb begin
    xu_off     = s2_x_q - bhdc_pkg::UPPER_X_LO[6:0];
    xl_off     = s2_x_q - bhdc_pkg::LOWER_X_LO[6:0];
    upper_prod = {10'b0, xu_off[5:0]} * bhdc_pkg::RECIP_3_5;
    duty_d     = 7'd0;
    heat_d     = 1'b0;
    if (s2_mode_q == bhdc_pkg::MODE_ON && !s2_emerg_q) begin
      case (s2_band_q)
        bhdc_pkg::BAND_HOT: begin
          duty_d = bhdc_pkg::DUTY_HOT;
          heat_d = 1'b1;
        end
        bhdc_pkg::BAND_UPPER: begin
          duty_d = bhdc_pkg::DUTY_UPPER + {1'b0, upper_prod[15:10]};
          heat_d = 1'b1;
        end
        bhdc_pkg::BAND_LOWER: begin
          duty_d = bhdc_pkg::DUTY_LOWER + {2'b00, xl_off[6:2]};
          heat_d = 1'b1;
        end
        bhdc_pkg::BAND_HOLD: begin
          duty_d = bhdc_pkg::DUTY_HOLD;
          heat_d = 1'b1;
        end
        default: begin
          duty_d = 7'd0;
          heat_d = 1'b0;
        end
      endcase
    end
  end

  logic [6:0]      s3_duty_q;
  logic            s3_heat_q;
  bhdc_pkg::mode_e s3_mode_q;
  logic [7:0]      s3_knob_q, s3_tgt_q;

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      s3_duty_q <= duty_d;
      s3_heat_q <= heat_d;
      s3_mode_q <= s2_mode_q;
      s3_knob_q <= s2_knob_q;
      s3_tgt_q  <= s2_tgt_q;
    end
  end

  // Stage 4: duty times PWM top.
  logic [22:0]     s4_p_q;
  logic [6:0]      s4_duty_q;
  logic            s4_heat_q;
  bhdc_pkg::mode_e s4_mode_q;
  logic [7:0]      s4_knob_q, s4_tgt_q;

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      s4_p_q    <= {16'b0, s3_duty_q} * {7'b0, cfg_q.pwm_top};
      s4_duty_q <= s3_duty_q;
      s4_heat_q <= s3_heat_q;
      s4_mode_q <= s3_mode_q;
      s4_knob_q <= s3_knob_q;
      s4_tgt_q  <= s3_tgt_q;
    end
  end

  // Stage 5: quotient estimate by reciprocal multiplication.
  logic [46:0] recip_prod;

  assign recip_prod = {24'b0, s4_p_q} * {23'b0, bhdc_pkg::DIV100_RECIP};

  logic [22:0]     s5_p_q;
  logic [15:0]     s5_q0_q;
  logic [6:0]      s5_duty_q;
  logic            s5_heat_q;
  bhdc_pkg::mode_e s5_mode_q;
  logic [7:0]      s5_knob_q, s5_tgt_q;

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      s5_p_q    <= s4_p_q;
      s5_q0_q   <= recip_prod[45:30];
      s5_duty_q <= s4_duty_q;
      s5_heat_q <= s4_heat_q;
      s5_mode_q <= s4_mode_q;
      s5_knob_q <= s4_knob_q;
      s5_tgt_q  <= s4_tgt_q;
    end
  end

  // Stage 6: correct the estimate by one and register the result.
  logic [22:0] rem;
  logic [15:0] cmp_d;

  always_comb begin
    rem   = s5_p_q - ({7'b0, s5_q0_q} * bhdc_pkg::DIV100_D);
    cmp_d = s5_q0_q + {15'b0, (rem >= bhdc_pkg::DIV100_D)};
  end

  bhdc_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (load[6]) begin
      out_q.duty_percent  <= s5_duty_q;
      out_q.compare_value <= cmp_d;
      out_q.system_mode   <= s5_mode_q;
      out_q.heating_on    <= s5_heat_q;
      out_q.knob_position <= s5_knob_q;
      out_q.target_temp   <= s5_tgt_q;
    end
  end

  assign out_valid_o = valid_q[6];
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The heater is driven exactly when the duty is non-zero.
  a_heat_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.heating_on == (out_data_o.duty_percent != 7'd0)))
    else $error("heating flag disagrees with duty");

  // Only on mode may drive the heater.
  a_heat_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.system_mode != bhdc_pkg::MODE_ON) |-> !out_data_o.heating_on)
    else $error("heater driven outside on mode");

  // Duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.duty_percent <= bhdc_pkg::DUTY_MAX))
    else $error("duty out of range");

  // Zero duty scales to a zero compare value.
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.duty_percent == 7'd0) |-> (out_data_o.compare_value == 16'd0))
    else $error("compare value non-zero at zero duty");

  // Requests are held off only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;

  // Knob codes that carry no movement.
  localparam logic [1:0] KNOB_IDLE     = 2'd0;
  localparam logic [1:0] KNOB_RESERVED = 2'd3;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  bhdc_pkg::in_t                   req_data  = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  bhdc_pkg::out_t                  rsp_data;
  logic                            cfg_we    = 1'b0;
  logic [bhdc_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [bhdc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Own copy of the registers and of the knob and target state.
  bhdc_pkg::cfg_t cfg_model  = bhdc_pkg::CFG_RESET;
  logic [7:0]     knob_pos   = bhdc_pkg::KNOB_RESET;
  logic [7:0]     target_deg = bhdc_pkg::TARGET_RESET;

  bhdc_pkg::out_t expected_results[$];
  int   failures   = 0;
  int   stall_left = 0;
  bit   send_idle  = 1'b1;
  bit   recv_idle  = 1'b1;

  banded_heater_duty_controller_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_data_o  (rsp_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hung handshake ends the run here.
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int bound(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Moves the knob, updates the target and works out the duty for one request.
  function automatic bhdc_pkg::out_t heater_response(bhdc_pkg::in_t req);
    logic [8:0]      raised;
    int              temp, setpoint, err, tol, x, duty, scaled;
    logic            heat;
    bhdc_pkg::mode_e mode;
    bhdc_pkg::out_t  res;
    temp = $signed(req.bed_temp);
    if (req.knob_step == bhdc_pkg::KNOB_UP) begin
      raised   = knob_pos + 9'd1;
      knob_pos = (raised > cfg_model.knob_max) ? cfg_model.knob_max : raised[7:0];
    end else if (req.knob_step == bhdc_pkg::KNOB_DOWN && knob_pos != 8'd0) begin
      knob_pos = knob_pos - 8'd1;
    end
    // The lower bound is tested first, which matters for an inverted range.
    if (knob_pos >= cfg_model.knob_on_threshold) begin
      if (knob_pos < cfg_model.target_min) target_deg = cfg_model.target_min;
      else if (knob_pos > cfg_model.target_max) target_deg = cfg_model.target_max;
      else target_deg = knob_pos;
    end
    if (temp >= int'(cfg_model.overheat_limit)) mode = bhdc_pkg::MODE_OVERHEAT;
    else if (knob_pos < cfg_model.knob_on_threshold) mode = bhdc_pkg::MODE_OFF;
    else mode = bhdc_pkg::MODE_ON;
    duty = 0;
    heat = 1'b0;
    if (mode == bhdc_pkg::MODE_ON) begin
      setpoint = int'(target_deg) * 16;
      err      = setpoint - temp;
      tol      = int'(cfg_model.hold_tolerance);
      heat     = 1'b1;
      if (err > 160) begin
        duty = 80;
      end else if (err > 80) begin
        x    = bound(err * 10 / 16, 50, 100);
        duty = 40 + (x - 50) * 30 / 50;
      end else if (err > tol) begin
        x    = bound(err * 20 / 16, 20, 100);
        duty = 20 + (x - 20) * 20 / 80;
      end else if (err < -tol) begin
        heat = 1'b0;
      end else begin
        duty = 15;
      end
      // Far above the target the heater is cut whatever the band says.
      if (temp > setpoint + int'(cfg_model.emergency_margin)) begin
        duty = 0;
        heat = 1'b0;
      end
    end
    scaled              = duty * int'(cfg_model.pwm_top) / 100;
    res.duty_percent    = duty[6:0];
    res.compare_value   = scaled[15:0];
    res.system_mode     = mode;
    res.heating_on      = heat;
    res.knob_position   = knob_pos;
    res.target_temp     = target_deg;
    return res;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // Checks each result taken, records each request taken, and paces the output stall.
  always @(posedge clk) begin
    bhdc_pkg::out_t want;
    if (rst_n) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none outstanding, got %p", $time, rsp_data);
          failures++;
        end else begin
          want = expected_results.pop_front();
          compare_field("duty_percent", 32'(want.duty_percent),
                        32'(rsp_data.duty_percent));
          compare_field("compare_value", 32'(want.compare_value),
                        32'(rsp_data.compare_value));
          compare_field("system_mode", 32'(want.system_mode),
                        32'(rsp_data.system_mode));
          compare_field("heating_on", 32'(want.heating_on),
                        32'(rsp_data.heating_on));
          compare_field("knob_position", 32'(want.knob_position),
                        32'(rsp_data.knob_position));
          compare_field("target_temp", 32'(want.target_temp),
                        32'(rsp_data.target_temp));
        end
        stall_left = recv_idle ? $urandom_range(0, 6) : 0;
      end
      if (req_valid && !req_stall) expected_results.push_back(heater_response(req_data));
    end
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Offers one request, after a random gap while send_idle is set, and returns at the edge that takes it.
  task automatic send_request(int temp, logic [1:0] step);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= '{bed_temp: temp[12:0], knob_step: step};
    do @(posedge clk); while (req_stall);
  endtask

  // Stops requests and waits until every outstanding result has been taken.
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(bhdc_pkg::cfg_reg_e idx, logic [bhdc_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
  endtask

  task automatic apply_config(bhdc_pkg::cfg_t c);
    settle();
    write_reg(bhdc_pkg::REG_KNOB_ON_THRESHOLD, bhdc_pkg::CFG_DATA_W'(c.knob_on_threshold));
    write_reg(bhdc_pkg::REG_KNOB_MAX, bhdc_pkg::CFG_DATA_W'(c.knob_max));
    write_reg(bhdc_pkg::REG_TARGET_MIN, bhdc_pkg::CFG_DATA_W'(c.target_min));
    write_reg(bhdc_pkg::REG_TARGET_MAX, bhdc_pkg::CFG_DATA_W'(c.target_max));
    write_reg(bhdc_pkg::REG_OVERHEAT_LIMIT, bhdc_pkg::CFG_DATA_W'(c.overheat_limit));
    write_reg(bhdc_pkg::REG_HOLD_TOLERANCE, bhdc_pkg::CFG_DATA_W'(c.hold_tolerance));
    write_reg(bhdc_pkg::REG_EMERGENCY_MARGIN, bhdc_pkg::CFG_DATA_W'(c.emergency_margin));
    write_reg(bhdc_pkg::REG_PWM_TOP, c.pwm_top);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_model = c;
  endtask

  // Temperatures mostly near the band edges, the margin and the overheat limit.
  function automatic int random_temp();
    int setpoint, hold, margin, t;
    setpoint = int'(target_deg) * 16;
    hold     = int'(cfg_model.hold_tolerance);
    margin   = int'(cfg_model.emergency_margin);
    case ($urandom_range(0, 9))
      0, 1:    t = int'($urandom_range(0, 8191)) - 4096;
      2:       t = int'(cfg_model.overheat_limit) + int'($urandom_range(0, 6)) - 3;
      3, 4, 5: t = setpoint + int'($urandom_range(0, 400)) - 200;
      6, 7:    t = setpoint + int'($urandom_range(0, 2 * hold + 4)) - (hold + 2);
      default: t = setpoint + margin + int'($urandom_range(0, 4)) - 2;
    endcase
    return bound(t, -4096, 4095);
  endfunction

  // Threshold kept near the knob so that the mode keeps changing.
  function automatic bhdc_pkg::cfg_t random_config();
    bhdc_pkg::cfg_t c;
    c.knob_on_threshold = 8'(bound(int'(knob_pos) + int'($urandom_range(0, 16)) - 8, 0, 255));
    c.knob_max          = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(int'(knob_pos), 255));
    if ($urandom_range(0, 3) == 0) begin
      c.target_min = 8'($urandom_range(0, 255));
      c.target_max = 8'($urandom_range(0, 255));
    end else begin
      c.target_min = 8'($urandom_range(0, 120));
      c.target_max = 8'($urandom_range(100, 255));
    end
    c.overheat_limit   = 12'($urandom_range(1600, 4095));
    c.hold_tolerance   = 8'($urandom_range(0, 255));
    c.emergency_margin = 10'($urandom_range(0, 1023));
    c.pwm_top          = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  // Band edges, overheat edge, temperature extremes and knob steps at the reset
  // settings, where the knob starts on the threshold and the target is 30 degrees.
  task automatic test_band_edges();
    send_request(319, KNOB_IDLE);
    send_request(320, KNOB_IDLE);
    send_request(399, KNOB_RESERVED);
    send_request(400, KNOB_IDLE);
    send_request(447, KNOB_IDLE);
    send_request(448, KNOB_IDLE);
    send_request(512, KNOB_IDLE);
    send_request(513, KNOB_IDLE);
    send_request(2559, KNOB_IDLE);
    send_request(2560, KNOB_IDLE);
    send_request(4095, KNOB_IDLE);
    send_request(-4096, KNOB_IDLE);
    send_request(-1024, KNOB_RESERVED);
    send_request(480, bhdc_pkg::KNOB_DOWN);
    send_request(480, bhdc_pkg::KNOB_DOWN);
    send_request(480, bhdc_pkg::KNOB_UP);
    send_request(480, bhdc_pkg::KNOB_UP);
    send_request(470, bhdc_pkg::KNOB_UP);
  endtask

  // A wide hold band empties the lower band; a zero margin cuts the heater
  // just above the target; a zero PWM top gives a zero compare value.
  task automatic test_emergency_and_zero_top();
    bhdc_pkg::cfg_t c;
    int             sp;
    c                  = bhdc_pkg::CFG_RESET;
    c.hold_tolerance   = 8'd255;
    c.emergency_margin = 10'd0;
    c.pwm_top          = 16'd0;
    apply_config(c);
    sp = int'(target_deg) * 16;
    send_request(sp, KNOB_IDLE);
    send_request(sp + 1, KNOB_IDLE);
    send_request(sp - 50, KNOB_IDLE);
    send_request(sp - 100, KNOB_IDLE);
    send_request(sp - 200, KNOB_IDLE);
    send_request(sp + 300, KNOB_IDLE);
  endtask

  // Drives the knob to the top of its range and holds it there.
  task automatic test_knob_climb();
    bhdc_pkg::cfg_t c;
    int             ups_left;
    int             pick;
    c = '{knob_on_threshold: 8'd0, knob_max: 8'd255, target_min: 8'd0,
          target_max: 8'd255, overheat_limit: 12'd4095, hold_tolerance: 8'd8,
          emergency_margin: 10'd1023, pwm_top: 16'd65535};
    apply_config(c);
    ups_left = 255 - int'(knob_pos) + 3;
    while (ups_left > 0) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_request(random_temp(), bhdc_pkg::KNOB_DOWN);
        ups_left++;
      end else if (pick == 1) begin
        send_request(random_temp(), $urandom_range(0, 1) ? KNOB_IDLE : KNOB_RESERVED);
      end else begin
        send_request(random_temp(), bhdc_pkg::KNOB_UP);
        ups_left--;
      end
    end
  endtask

  // Knob left above a lowered maximum, with an inverted target range.
  task automatic test_knob_above_max();
    bhdc_pkg::cfg_t c;
    c = '{knob_on_threshold: 8'd90, knob_max: 8'd100, target_min: 8'd200,
          target_max: 8'd100, overheat_limit: 12'd4095, hold_tolerance: 8'd32,
          emergency_margin: 10'd240, pwm_top: 16'd511};
    apply_config(c);
    send_request(random_temp(), bhdc_pkg::KNOB_DOWN);
    send_request(random_temp(), bhdc_pkg::KNOB_UP);
    send_request(random_temp(), bhdc_pkg::KNOB_UP);
    send_request(random_temp(), bhdc_pkg::KNOB_DOWN);
    send_request(random_temp(), KNOB_RESERVED);
  endtask

  // Random requests under both extreme settings and several random ones.
  task automatic test_random_settings();
    bhdc_pkg::cfg_t c;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) c = '0;
      else if (phase == 1) c = '1;
      else c = random_config();
      apply_config(c);
      for (int i = 0; i < 32; i++) begin
        if (i % 16 == 0) begin
          send_idle = ($urandom_range(0, 2) != 0);
          recv_idle = ($urandom_range(0, 2) != 0);
        end
        send_request(random_temp(), 2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_band_edges();
    test_emergency_and_zero_top();
    test_knob_climb();
    test_knob_above_max();
    test_random_settings();
    settle();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
